/* rtl/core/drpt_pkg.sv */
// Shared types and constants for the deduplicating round-robin pending table.
package drpt_pkg;

  // Default table geometry.
  localparam int unsigned DefTableDepth   = 24;
  localparam int unsigned DefRequestWidth = 32;

  // Operation codes carried by the mode field.
  typedef enum logic [1:0] {
    MODE_PEND  = 2'd0,
    MODE_TAKE  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // Update commands from the sequencer to the slot store.
  typedef struct packed {
    logic clr;     // empty every slot
    logic wr_en;   // store the write data and mark the slot full
    logic inv_en;  // mark the slot empty
  } slot_cmd_t;

endpackage

/* rtl/core/drpt_slot_store.sv */
// Slot store: request words with one occupancy bit per slot and a single read port.
module drpt_slot_store import drpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH   = DefTableDepth,
  parameter int unsigned REQUEST_WIDTH = DefRequestWidth,
  parameter int unsigned IdxW          = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  slot_cmd_t                cmd_i,
  input  logic [IdxW-1:0]          wr_idx_i,
  input  logic [REQUEST_WIDTH-1:0] wr_data_i,
  input  logic [IdxW-1:0]          rd_idx_i,
  output logic [REQUEST_WIDTH-1:0] rd_data_o,
  output logic                     rd_valid_o,
  output logic                     any_valid_o
);

  logic [REQUEST_WIDTH-1:0] slots_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_q;
  logic [REQUEST_WIDTH-1:0] rd_data_q;
  logic                     rd_valid_q;

  // Request words; an empty slot's word is never looked at. The read is
  // registered, so the data of the slot addressed now shows up next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      slots_q[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= slots_q[rd_idx_i];
  end

  // Occupancy bits; reset and clear empty the whole table at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr) begin
      valid_q <= '0;
    end else if (cmd_i.wr_en) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (cmd_i.inv_en) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  // Occupancy of the addressed slot, registered alongside its data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  // Single read port driven by the next scan index.
  assign rd_data_o   = rd_data_q;
  assign rd_valid_o  = rd_valid_q;
  assign any_valid_o = |valid_q;

endmodule

/* rtl/core/dedup_round_robin_pending_table.sv */
// Deduplicating round-robin pending table: one slot is read per cycle by a
// small sequencer. A pend of a new request checks every slot for a duplicate
// and remembers the lowest empty one on the way; a pend whose request is
// already pending stops at the matching slot; a take stops at the first full
// slot at or after next_slot, wrapping round; and a clear, a pend of zero or
// an unused mode go straight to the final step. The block is not ready while
// an item is in progress; it is ready again in the cycle after the result is
// loaded into the output register, and a result that is not taken holds the
// next item in its final step.
module dedup_round_robin_pending_table import drpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH   = DefTableDepth,
  parameter int unsigned REQUEST_WIDTH = DefRequestWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [REQUEST_WIDTH-1:0] request_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     accepted_o,
  output logic [REQUEST_WIDTH-1:0] taken_request_o,
  output logic                     table_empty_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  state_e                   state_q, state_d;
  logic [IdxW-1:0]          next_slot_q, next_slot_d;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               mode_q, mode_d;
  logic [REQUEST_WIDTH-1:0] req_q, req_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [IdxW-1:0]          cnt_q, cnt_d;
  logic                     free_found_q, free_found_d;
  logic [IdxW-1:0]          free_idx_q, free_idx_d;
  logic                     acc_q, acc_d;
  logic [REQUEST_WIDTH-1:0] taken_q, taken_d;
  logic                     out_acc_q, out_acc_d;
  logic [REQUEST_WIDTH-1:0] out_taken_q, out_taken_d;
  logic                     out_empty_q, out_empty_d;

  slot_cmd_t                cmd;
  logic [IdxW-1:0]          wr_idx;
  logic [REQUEST_WIDTH-1:0] rd_data;
  logic                     rd_valid;
  logic                     any_valid;
  logic                     last_scan;
  logic [IdxW-1:0]          idx_inc;

  // The store registers its read, so it is addressed with the next scan index.
  drpt_slot_store #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .REQUEST_WIDTH(REQUEST_WIDTH),
    .IdxW         (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_idx_i   (wr_idx),
    .wr_data_i  (req_q),
    .rd_idx_i   (idx_d),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid),
    .any_valid_o(any_valid)
  );

  // Round-robin successor of the current scan slot.
  assign idx_inc   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign last_scan = (cnt_q == LastIdx);

  // Sequencer: accept, scan one slot per cycle where the mode needs it, then load the result.
  always_comb begin
    state_d      = state_q;
    next_slot_d  = next_slot_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    req_d        = req_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    acc_d        = acc_q;
    taken_d      = taken_q;
    out_acc_d    = out_acc_q;
    out_taken_d  = out_taken_q;
    out_empty_d  = out_empty_q;
    cmd          = '0;
    wr_idx       = idx_q;

    // The output beat leaves when the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          req_d        = request_i;
          acc_d        = 1'b0;
          taken_d      = '0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          state_d      = S_DONE;
          case (mode_i)
            MODE_PEND: begin
              if (request_i != '0) begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            MODE_TAKE: begin
              idx_d   = next_slot_q;
              state_d = S_SCAN;
            end
            MODE_CLEAR: begin
              cmd.clr     = 1'b1;
              next_slot_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        idx_d = idx_inc;
        cnt_d = cnt_q + 1'b1;
        case (mode_q)
          MODE_PEND: begin
            if (rd_valid && (rd_data == req_q)) begin
              // Already pending: accept without a change.
              acc_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              if (!rd_valid && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = idx_q;
              end
              if (last_scan) begin
                state_d = S_DONE;
                if (free_found_q || !rd_valid) begin
                  cmd.wr_en = 1'b1;
                  wr_idx    = free_found_q ? free_idx_q : idx_q;
                  acc_d     = 1'b1;
                end
              end
            end
          end
          MODE_TAKE: begin
            if (rd_valid) begin
              cmd.inv_en  = 1'b1;
              taken_d     = rd_data;
              next_slot_d = idx_inc;
              state_d     = S_DONE;
            end else if (last_scan) begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_taken_d = taken_q;
          out_empty_d = !any_valid;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_slot_q <= next_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    req_q        <= req_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    acc_q        <= acc_d;
    taken_q      <= taken_d;
    out_acc_q    <= out_acc_d;
    out_taken_q  <= out_taken_d;
    out_empty_q  <= out_empty_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign taken_request_o = out_taken_q;
  assign table_empty_o   = out_empty_q;

endmodule

/* rtl/core/drpt_checker.sv */
// Port-level checks for the pending table, bound to the top level.
module drpt_checker import drpt_pkg::*; #(
  parameter int unsigned REQUEST_WIDTH = DefRequestWidth
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     accepted_o,
  input logic [REQUEST_WIDTH-1:0] taken_request_o,
  input logic                     table_empty_o
);

  // A result beat that is not taken holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(accepted_o) && $stable(taken_request_o)
      && $stable(table_empty_o))
    else $error("result beat changed while stalled");

  // One item at a time: the block is busy right after an input beat.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // An accepted pend leaves the table non-empty.
  a_acc_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !table_empty_o)
    else $error("accepted pend but table reported empty");

  // A pend result never carries a taken request.
  a_acc_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> (taken_request_o == '0))
    else $error("accepted pend with a taken request");

endmodule

bind dedup_round_robin_pending_table drpt_checker #(
  .REQUEST_WIDTH(REQUEST_WIDTH)
) u_drpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .taken_request_o(taken_request_o),
  .table_empty_o  (table_empty_o)
);

/* tb/tb_top.sv */
// Self-checking testbench for the deduplicating round-robin pending table.
`timescale 1ns / 100ps

module tb_top;
  import drpt_pkg::*;

  localparam int unsigned Depth     = DefTableDepth;
  localparam int unsigned ReqW      = DefRequestWidth;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned RandBeats = 600;
  localparam int unsigned PoolSize  = 32;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 400000;

  // One result beat of the table.
  typedef struct packed {
    logic            accepted;
    logic [ReqW-1:0] taken;
    logic            empty;
  } table_resp_t;

  // One row of the directed stimulus; reps above one pends consecutive words.
  typedef struct {
    logic [1:0]      mode;
    logic [ReqW-1:0] req;
    int unsigned     reps;
    bit              has_fixed;
    table_resp_t     fixed;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      mode_i;
  logic [ReqW-1:0] request_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            accepted_o;
  logic [ReqW-1:0] taken_request_o;
  logic            table_empty_o;

  // Side information that travels with the beat on offer.
  bit              row_fixed;
  table_resp_t     row_resp;

  // Shadow copy of the table and its take pointer.
  logic [ReqW-1:0] shadow_slots [Depth];
  int unsigned     take_ptr;

  table_resp_t     queued_resps [$];
  int unsigned     mismatches;
  int unsigned     resp_cnt;
  int unsigned     burst_left;
  int unsigned     cycle_cnt;

  dedup_round_robin_pending_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .request_i       (request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .taken_request_o (taken_request_o),
    .table_empty_o   (table_empty_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow table and return the beat it causes.
  function automatic table_resp_t table_op(logic [1:0] mode, logic [ReqW-1:0] req);
    table_resp_t resp;
    bit          done;
    int unsigned s;
    resp = '0;
    done = 1'b0;
    case (mode)
      MODE_PEND: begin
        if (req != '0) begin
          for (int i = 0; i < Depth; i++) begin
            if (shadow_slots[i] == req) done = 1'b1;
          end
          for (int i = 0; i < Depth && !done; i++) begin
            if (shadow_slots[i] == '0) begin
              shadow_slots[i] = req;
              done = 1'b1;
            end
          end
          resp.accepted = done;
        end
      end
      MODE_TAKE: begin
        for (int i = 0; i < Depth && !done; i++) begin
          s = (take_ptr + i) % Depth;
          if (shadow_slots[s] != '0) begin
            resp.taken      = shadow_slots[s];
            shadow_slots[s] = '0;
            take_ptr        = (s + 1) % Depth;
            done            = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < Depth; i++) shadow_slots[i] = '0;
        take_ptr = 0;
      end
      default: ;
    endcase
    resp.empty = 1'b1;
    for (int i = 0; i < Depth; i++) begin
      if (shadow_slots[i] != '0) resp.empty = 1'b0;
    end
    return resp;
  endfunction

  // Record accepted input beats and check result beats in order.
  always @(posedge clk_i) begin : monitor_proc
    table_resp_t pred;
    table_resp_t want;
    table_resp_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pred = table_op(mode_i, request_i);
        queued_resps.push_back(row_fixed ? row_resp : pred);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{accepted_o, taken_request_o, table_empty_o};
        resp_cnt++;
        if (queued_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat %0d arrived with nothing outstanding", resp_cnt);
          end
        end else begin
          want = queued_resps.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d: accepted %0b/%0b taken %08h/%08h empty %0b/%0b (exp/act)",
                       resp_cnt, want.accepted, got.accepted, want.taken, got.taken,
                       want.empty, got.empty);
            end
          end
        end
      end
    end
  end

  // Receiver: segments of free flow, light and heavy stalling, plus one long hold-off.
  initial begin : receiver_proc
    bit          held;
    int unsigned style;
    int unsigned len;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && resp_cnt >= 150) begin
        // Hold off long enough for the block to fill and stall its input.
        held = 1'b1;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        style = $urandom_range(0, 2);
        len   = $urandom_range(1, 40);
        repeat (len) begin
          @(negedge clk_i);
          case (style)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= ($urandom_range(0, 1) == 0);
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Run timeout.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL dedup_round_robin_pending_table");
    $finish;
  end

  // Sender pacing: bursts of beats separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      row_fixed  <= 1'b0;
      mode_i     <= 2'($urandom_range(0, 3));
      request_i  <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offer one beat and hold it until the block takes it.
  task automatic offer_beat(logic [1:0] mode, logic [ReqW-1:0] req, bit has_fixed,
                            table_resp_t fixed);
    pace();
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    request_i  <= req;
    row_fixed  <= has_fixed;
    row_resp   <= fixed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic dir_row_t mk_row(logic [1:0] mode, logic [ReqW-1:0] req,
                                      int unsigned reps, bit has_fixed, logic acc,
                                      logic [ReqW-1:0] taken, logic empty);
    dir_row_t row;
    row.mode      = mode;
    row.req       = req;
    row.reps      = reps;
    row.has_fixed = has_fixed;
    row.fixed     = '{acc, taken, empty};
    return row;
  endfunction

  // Main stimulus: reset, directed rows, then random traffic and the drain.
  initial begin : stimulus_proc
    dir_row_t        dir_rows [19];
    logic [ReqW-1:0] pool [PoolSize];
    logic [1:0]      mode;
    logic [ReqW-1:0] req;
    int unsigned     pend_pct;
    int unsigned     pick;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_PEND;
    request_i   = '0;
    row_fixed   = 1'b0;
    row_resp    = '0;
    mismatches  = 0;
    resp_cnt    = 0;
    burst_left  = 0;
    take_ptr    = 0;
    for (int i = 0; i < Depth; i++) shadow_slots[i] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; the fixed columns are only filled where the answer is obvious.
    dir_rows[0]  = mk_row(MODE_TAKE,  '0,            1,     1'b1, 1'b0, '0, 1'b1);
    dir_rows[1]  = mk_row(MODE_PEND,  '0,            1,     1'b1, 1'b0, '0, 1'b1);
    dir_rows[2]  = mk_row(ModeUnused, '1,            1,     1'b1, 1'b0, '0, 1'b1);
    dir_rows[3]  = mk_row(MODE_CLEAR, '1,            1,     1'b1, 1'b0, '0, 1'b1);
    dir_rows[4]  = mk_row(MODE_PEND,  '1,            1,     1'b1, 1'b1, '0, 1'b0);
    dir_rows[5]  = mk_row(MODE_PEND,  '1,            1,     1'b1, 1'b1, '0, 1'b0);
    dir_rows[6]  = mk_row(MODE_PEND,  32'h1,         1,     1'b1, 1'b1, '0, 1'b0);
    dir_rows[7]  = mk_row(MODE_TAKE,  '0,            1,     1'b1, 1'b0, '1, 1'b0);
    dir_rows[8]  = mk_row(MODE_PEND,  32'h8000_0000, 1,     1'b0, 1'b0, '0, 1'b0);
    dir_rows[9]  = mk_row(MODE_TAKE,  '0,            1,     1'b0, 1'b0, '0, 1'b0);
    dir_rows[10] = mk_row(MODE_TAKE,  '0,            1,     1'b0, 1'b0, '0, 1'b0);
    dir_rows[11] = mk_row(MODE_PEND,  32'h100,       Depth, 1'b0, 1'b0, '0, 1'b0);
    dir_rows[12] = mk_row(MODE_PEND,  32'hDEAD_BEEF, 1,     1'b1, 1'b0, '0, 1'b0);
    dir_rows[13] = mk_row(MODE_PEND,  32'h110,       1,     1'b1, 1'b1, '0, 1'b0);
    dir_rows[14] = mk_row(MODE_TAKE,  '0,            1,     1'b0, 1'b0, '0, 1'b0);
    dir_rows[15] = mk_row(MODE_PEND,  32'hA5A5_5A5A, 1,     1'b0, 1'b0, '0, 1'b0);
    dir_rows[16] = mk_row(ModeUnused, 32'h5A5A_A5A5, 1,     1'b1, 1'b0, '0, 1'b0);
    dir_rows[17] = mk_row(MODE_CLEAR, '0,            1,     1'b1, 1'b0, '0, 1'b1);
    dir_rows[18] = mk_row(MODE_TAKE,  '1,            1,     1'b1, 1'b0, '0, 1'b1);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        offer_beat(dir_rows[i].mode, dir_rows[i].req + k, dir_rows[i].has_fixed,
                   dir_rows[i].fixed);
      end
    end

    // A small pool of words makes duplicates common and lets the table fill.
    for (int i = 0; i < PoolSize; i++) begin
      pool[i] = $urandom;
      if (pool[i] == '0) pool[i] = 1;
    end

    // Random traffic in phases that lean toward filling or draining the table.
    pend_pct = 50;
    for (int n = 0; n < RandBeats; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       pend_pct = 85;
          1:       pend_pct = 50;
          default: pend_pct = 20;
        endcase
      end
      pick = $urandom_range(0, 99);
      req  = $urandom;
      if (pick < 2) begin
        mode = MODE_CLEAR;
      end else if (pick < 4) begin
        mode = ModeUnused;
      end else if ($urandom_range(0, 99) < pend_pct) begin
        mode = MODE_PEND;
        pick = $urandom_range(0, 99);
        if (pick < 5) req = '0;
        else if (pick < 70) req = pool[$urandom_range(0, PoolSize - 1)];
      end else begin
        mode = MODE_TAKE;
      end
      offer_beat(mode, req, 1'b0, '0);
    end

    // Drain: wait for every outstanding result, then a little longer.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    row_fixed  <= 1'b0;
    while (queued_resps.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS dedup_round_robin_pending_table");
    end else begin
      $display("FAIL dedup_round_robin_pending_table");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/drpt_pkg.sv
rtl/core/drpt_slot_store.sv
rtl/core/dedup_round_robin_pending_table.sv
rtl/core/drpt_checker.sv
tb/tb_top.sv
